### sv/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and helper functions for the roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    // ascii codes of the roman symbols
    localparam logic [7:0] SYM_I    = 8'h49;
    localparam logic [7:0] SYM_V    = 8'h56;
    localparam logic [7:0] SYM_X    = 8'h58;
    localparam logic [7:0] SYM_L    = 8'h4C;
    localparam logic [7:0] SYM_C    = 8'h43;
    localparam logic [7:0] SYM_D    = 8'h44;
    localparam logic [7:0] SYM_M    = 8'h4D;
    localparam logic [7:0] SYM_NONE = 8'h00;

    localparam int NUM_MAX     = 4999;
    localparam int THOUSAND    = 1000;
    localparam int HUNDRED     = 100;
    localparam int TEN         = 10;
    localparam int MAX_THOU    = 4;
    localparam int MAX_DIGIT   = 9;
    localparam int NUM_W       = 13;

    // decimal positions, most significant first
    typedef enum logic [1:0] {
        DIG_THOU = 2'd0,
        DIG_HUND = 2'd1,
        DIG_TENS = 2'd2,
        DIG_UNIT = 2'd3
    } rne_digit_t;

    // classified number handed from front to back
    typedef struct packed {
        logic       err;
        logic [2:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] unit;
        logic [3:0] nz;     // nonzero mask, bit 0 = thousands
    } rne_item_t;

    // thousands count of a value below 8192 (saturates at four)
    function automatic logic [2:0] thou_of(input logic [NUM_W-1:0] v);
        logic [2:0] q;
        q = '0;
        for (int k = 1; k <= MAX_THOU; k++) begin
            if (v >= NUM_W'(k * THOUSAND)) begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

    // hundreds digit of a value below 1000
    function automatic logic [3:0] hund_of(input logic [9:0] v);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= MAX_DIGIT; k++) begin
            if (v >= 10'(k * HUNDRED)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // tens digit of a value below 100
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= MAX_DIGIT; k++) begin
            if (v >= 7'(k * TEN)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // symbols needed for one decimal digit in subtractive form
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        case (d) inside
            4'd1, 4'd5:        n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:              n = 3'd2;
            4'd3, 4'd7:        n = 3'd3;
            4'd8:              n = 3'd4;
            default:           n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Accepts numbers, range checks them and splits them into decimal digits
// over three pipeline stages.
// ----------------------------------------------------------------------------
module rne_front
    import rne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [12:0]      number,
    output logic             full,
    output rne_item_t        item,
    output logic             item_valid,
    input  logic             item_ready
);

    logic             s1_v_reg;
    logic             s1_err_reg;
    logic [2:0]       s1_thou_reg;
    logic [9:0]       s1_rem_reg;
    logic             s2_v_reg;
    logic             s2_err_reg;
    logic [2:0]       s2_thou_reg;
    logic [3:0]       s2_hund_reg;
    logic [6:0]       s2_rem_reg;
    logic             s3_v_reg;
    rne_item_t        s3_item_reg;

    logic             s1_err_next;
    logic [2:0]       s1_thou_next;
    logic [9:0]       s1_rem_next;
    logic [3:0]       s2_hund_next;
    logic [6:0]       s2_rem_next;
    rne_item_t        s3_item_next;
    logic             s1_adv;
    logic             s2_adv;
    logic             s3_adv;
    logic             in_xfer;

    // stage advance under back pressure
    assign s3_adv  = s3_v_reg && item_ready;
    assign s2_adv  = s2_v_reg && (!s3_v_reg || s3_adv);
    assign s1_adv  = s1_v_reg && (!s2_v_reg || s2_adv);
    assign full    = s1_v_reg && !s1_adv;
    assign in_xfer = push && !full;

    // stage 1: range check and thousands
    always_comb
    begin
        s1_err_next  = (number == '0) || (number > NUM_W'(NUM_MAX));
        s1_thou_next = thou_of(number);
        s1_rem_next  = 10'(number - NUM_W'(s1_thou_next) * NUM_W'(THOUSAND));
    end

    // stage 2: hundreds
    always_comb
    begin
        s2_hund_next = hund_of(s1_rem_reg);
        s2_rem_next  = 7'(s1_rem_reg - 10'(s2_hund_next) * 10'(HUNDRED));
    end

    // stage 3: tens, units and nonzero mask
    always_comb
    begin
        s3_item_next.err  = s2_err_reg;
        s3_item_next.thou = s2_thou_reg;
        s3_item_next.hund = s2_hund_reg;
        s3_item_next.tens = tens_of(s2_rem_reg);
        s3_item_next.unit = 4'(s2_rem_reg - 7'(s3_item_next.tens) * 7'(TEN));
        s3_item_next.nz   = {s3_item_next.unit != '0, s3_item_next.tens != '0,
                             s2_hund_reg != '0, s2_thou_reg != '0};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer || s1_adv)
            begin
                s1_v_reg <= in_xfer;
            end
            if (s1_adv || s2_adv)
            begin
                s2_v_reg <= s1_adv;
            end
            if (s2_adv || s3_adv)
            begin
                s3_v_reg <= s2_adv;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_err_reg  <= s1_err_next;
            s1_thou_reg <= s1_thou_next;
            s1_rem_reg  <= s1_rem_next;
        end
        if (s1_adv)
        begin
            s2_err_reg  <= s1_err_reg;
            s2_thou_reg <= s1_thou_reg;
            s2_hund_reg <= s2_hund_next;
            s2_rem_reg  <= s2_rem_next;
        end
        if (s2_adv)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign item       = s3_item_reg;
    assign item_valid = s3_v_reg;

endmodule

### sv/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue
// Two-entry queue of classified numbers between front and back.
// ----------------------------------------------------------------------------
module rne_queue
    import rne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  rne_item_t   wr_data,
    output logic        wr_ready,
    input  logic        rd_en,
    output rne_item_t   rd_data,
    output logic        rd_valid
);

    rne_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr_xfer;
    logic        rd_xfer;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign wr_xfer  = wr_en && wr_ready;
    assign rd_xfer  = rd_en && rd_valid;
    assign rd_data  = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_xfer)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_xfer)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_xfer && !rd_xfer)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_xfer && !wr_xfer)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_xfer)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Walks the digits of one classified number and emits one roman symbol per
// cycle into an output register, while that register is empty or popped.
// ----------------------------------------------------------------------------
module rne_back
    import rne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rne_item_t   item,
    input  logic        item_valid,
    output logic        item_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        error
);

    logic [3:0]  done_reg;
    logic [1:0]  pos_reg;
    logic        out_v_reg;
    logic [7:0]  symbol_reg;
    logic        last_reg;
    logic        error_reg;

    logic [3:0]  remain;
    logic [3:0]  others;
    rne_digit_t  cur_idx;
    logic [3:0]  cur_d;
    logic [7:0]  sym_one;
    logic [7:0]  sym_five;
    logic [7:0]  sym_ten;
    logic [2:0]  cur_len;
    logic [7:0]  symbol_next;
    logic        last_next;
    logic        digit_end;
    logic        last_digit;
    logic        out_free;
    logic        fire;

    assign out_free = !out_v_reg || pop;
    assign fire     = item_valid && out_free;

    // pick the leading digit not yet emitted
    always_comb
    begin
        remain = item.nz & ~done_reg;
        if (remain[0])
        begin
            cur_idx = DIG_THOU;
        end
        else if (remain[1])
        begin
            cur_idx = DIG_HUND;
        end
        else if (remain[2])
        begin
            cur_idx = DIG_TENS;
        end
        else
        begin
            cur_idx = DIG_UNIT;
        end
        others     = remain & ~(4'b0001 << cur_idx);
        last_digit = (others == '0);
    end

    // digit value and its symbol set
    always_comb
    begin
        case (cur_idx)
            DIG_THOU:
            begin
                cur_d    = {1'b0, item.thou};
                sym_one  = SYM_M;
                sym_five = SYM_M;
                sym_ten  = SYM_M;
            end
            DIG_HUND:
            begin
                cur_d    = item.hund;
                sym_one  = SYM_C;
                sym_five = SYM_D;
                sym_ten  = SYM_M;
            end
            DIG_TENS:
            begin
                cur_d    = item.tens;
                sym_one  = SYM_X;
                sym_five = SYM_L;
                sym_ten  = SYM_C;
            end
            default:
            begin
                cur_d    = item.unit;
                sym_one  = SYM_I;
                sym_five = SYM_V;
                sym_ten  = SYM_X;
            end
        endcase
    end

    // symbol at the current position of the digit
    always_comb
    begin
        if (cur_idx == DIG_THOU)
        begin
            cur_len     = item.thou;
            symbol_next = SYM_M;
        end
        else
        begin
            cur_len = digit_len(cur_d);
            case (cur_d) inside
                4'd9:        symbol_next = (pos_reg == 2'd0) ? sym_one : sym_ten;
                4'd4:        symbol_next = (pos_reg == 2'd0) ? sym_one : sym_five;
                [4'd5:4'd8]: symbol_next = (pos_reg == 2'd0) ? sym_five : sym_one;
                default:     symbol_next = sym_one;
            endcase
        end
        digit_end = ({1'b0, pos_reg} == (cur_len - 3'd1));
        last_next = digit_end && last_digit;
        item_pop  = fire && (item.err || last_next);
    end

    // digit walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            pos_reg  <= '0;
        end
        else if (fire)
        begin
            if (item_pop)
            begin
                done_reg <= '0;
                pos_reg  <= '0;
            end
            else if (digit_end)
            begin
                done_reg <= done_reg | (4'b0001 << cur_idx);
                pos_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_v_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_v_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            symbol_reg <= item.err ? SYM_NONE : symbol_next;
            last_reg   <= item.err || last_next;
            error_reg  <= item.err;
        end
    end

    assign empty  = !out_v_reg;
    assign symbol = symbol_reg;
    assign last   = last_reg;
    assign error  = error_reg;

endmodule

### sv/roman_numeral_encoder_unit.sv
// a number passes the front stages and a queue entry before the back sequencer
// emits one symbol per cycle while its output is empty or popped; a numeral has
//   1 to 16 symbols and an error has 1
// the front accepts a new number every cycle until its stages and queue fill
// reset: asynchronous active low, clears all valid bits, queue and sequencer
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit
// Converts binary numbers into runs of ascii roman symbols, marking the last
// symbol of each run and flagging numbers outside 1 to 4999.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_unit
    import rne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [12:0] number,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        error
);

    rne_item_t   front_item;
    logic        front_valid;
    logic        queue_ready;
    rne_item_t   back_item;
    logic        back_valid;
    logic        back_pop;

    // classify and split numbers
    rne_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .number     (number),
        .full       (full),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (queue_ready)
    );

    // decoupling queue
    rne_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_item),
        .wr_ready (queue_ready),
        .rd_en    (back_pop),
        .rd_data  (back_item),
        .rd_valid (back_valid)
    );

    // symbol sequencer
    rne_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_pop   (back_pop),
        .empty      (empty),
        .pop        (pop),
        .symbol     (symbol),
        .last       (last),
        .error      (error)
    );

endmodule
